// ===== hw/rtl/patc_pkg.sv =====
// Shared types, widths, register indexes and constants of the packet airtime calculator.
package patc_pkg;

  localparam int unsigned LEN_W      = 8;
  localparam int unsigned AIRTIME_W  = 26;
  localparam int unsigned SF_W       = 4;
  localparam int unsigned BW_W       = 19;
  localparam int unsigned CR_W       = 4;
  localparam int unsigned PRE_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 19;

  // m = 2*len + 7 + 4*crc - sf, at most 516
  localparam int unsigned M_W     = 10;
  // d = sf - 2*ldro, 3..12
  localparam int unsigned D_W     = 4;
  // ceil(m / d), at most 172
  localparam int unsigned BLK_W   = 8;
  localparam int unsigned BC_W    = BLK_W + CR_W;
  localparam int unsigned QTR_W   = 19;
  localparam int unsigned Q250_W  = 27;
  // quarters * 250 * 2^sf + bw - 1
  localparam int unsigned NUM_W   = 39;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [SF_W-1:0] SF_MIN = SF_W'(5);
  localparam logic [SF_W-1:0] SF_MAX = SF_W'(12);
  localparam logic [BW_W-1:0] BW_MIN = BW_W'(7812);
  localparam logic [BW_W-1:0] BW_MAX = BW_W'(500000);

  // 8*len + 28 + 16*crc - 4*sf is a multiple of four: work in quarters of it
  localparam logic [M_W-1:0]    M_BASE    = M_W'(7);
  localparam logic [M_W-1:0]    M_CRC     = M_W'(4);
  // 4*4.25 preamble tail plus 4*8 header symbols
  localparam logic [QTR_W-1:0]  QTR_BASE  = QTR_W'(49);
  localparam logic [Q250_W-1:0] MS_SCALE  = Q250_W'(250);

  localparam logic [CFG_IDX_W-1:0] REG_SF   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BW   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CR   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PRE  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_LDRO = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_CRC  = CFG_IDX_W'(5);

  typedef struct packed {
    logic [SF_W-1:0]  sf;
    logic [BW_W-1:0]  bw;
    logic [CR_W-1:0]  cr;
    logic [PRE_W-1:0] pre;
    logic             ldro;
    logic             crc;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sf:   SF_W'(7),
    bw:   BW_W'(250000),
    cr:   CR_W'(5),
    pre:  PRE_W'(16),
    ldro: 1'b0,
    crc:  1'b1
  };

  typedef struct packed {
    logic [M_W-1:0] m;
    logic [D_W-1:0] d;
  } item_t;

  function automatic logic [SF_W-1:0] clamp_sf(input logic [SF_W-1:0] v);
    logic [SF_W-1:0] r;
    r = v;
    if (v < SF_MIN) r = SF_MIN;
    if (v > SF_MAX) r = SF_MAX;
    return r;
  endfunction

  function automatic logic [BW_W-1:0] clamp_bw(input logic [BW_W-1:0] v);
    logic [BW_W-1:0] r;
    r = v;
    if (v < BW_MIN) r = BW_MIN;
    if (v > BW_MAX) r = BW_MAX;
    return r;
  endfunction

endpackage

// ===== hw/rtl/patc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module patc_div #(
  parameter int unsigned NumW = 10,
  parameter int unsigned DvsW = 4,
  parameter int unsigned QuoW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [NumW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            valid_o,
  output logic [QuoW-1:0] quotient_o
);

  // caller guarantees dividend >> QuoW is below the divisor
  logic            vld_q [QuoW];
  logic [DvsW-1:0] rem_q [QuoW];
  logic [QuoW-1:0] low_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];
  logic [DvsW-1:0] dvs_q [QuoW];

  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    logic            vld_in;
    logic [DvsW-1:0] rem_in;
    logic [QuoW-1:0] low_in;
    logic [QuoW-1:0] quo_in;
    logic [DvsW-1:0] dvs_in;
    logic [DvsW:0]   trial;
    logic            ge;
    logic [DvsW-1:0] rem_d;

    if (s == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = DvsW'(dividend_i >> QuoW);
      assign low_in = dividend_i[QuoW-1:0];
      assign quo_in = '0;
      assign dvs_in = divisor_i;
    end else begin : g_next
      assign vld_in = vld_q[s-1];
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
      assign dvs_in = dvs_q[s-1];
    end

    assign trial = {rem_in, low_in[QuoW-1]};
    assign ge    = trial >= {1'b0, dvs_in};
    assign rem_d = ge ? DvsW'(trial - {1'b0, dvs_in}) : DvsW'(trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d;
      low_q[s] <= low_in << 1;
      quo_q[s] <= {quo_in[QuoW-2:0], ge};
      dvs_q[s] <= dvs_in;
    end
  end

  assign valid_o    = vld_q[QuoW-1];
  assign quotient_o = quo_q[QuoW-1];

endmodule

// ===== hw/rtl/patc_front.sv =====
// Front end: takes requests, works out the block numerator and divisor.
module patc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [patc_pkg::LEN_W-1:0] payload_length_i,
  input  patc_pkg::cfg_t             cfg_i,
  input  logic                       full_i,
  output logic                       push_o,
  output patc_pkg::item_t            item_o
);

  logic                      vld_q;
  patc_pkg::item_t           item_q;
  patc_pkg::item_t           item_d;
  logic [patc_pkg::M_W-1:0]  sum;
  logic                      accept;

  assign busy   = vld_q && full_i;
  assign accept = start && !busy;
  assign push_o = vld_q && !full_i;
  assign item_o = item_q;

  // payload blocks = ceil(m / d), m clamped at zero
  always_comb begin
    sum = patc_pkg::M_W'({payload_length_i, 1'b0}) + patc_pkg::M_BASE
        + (cfg_i.crc ? patc_pkg::M_CRC : '0);
    item_d.m = (sum > patc_pkg::M_W'(cfg_i.sf)) ? sum - patc_pkg::M_W'(cfg_i.sf) : '0;
    item_d.d = patc_pkg::D_W'(cfg_i.sf - {cfg_i.ldro, 1'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!busy) begin
      vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== hw/rtl/patc_fifo.sv =====
// Short request queue between front and back; drains one entry per cycle.
module patc_fifo #(
  parameter int unsigned Depth = patc_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  patc_pkg::item_t item_i,
  output logic            full_o,
  output logic            valid_o,
  output patc_pkg::item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  patc_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign pop     = cnt_q != '0;
  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = pop;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== hw/rtl/patc_back.sv =====
// Back end: block division, quarter-symbol count, scaling and the bandwidth division.
module patc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  patc_pkg::item_t                item_i,
  input  patc_pkg::cfg_t                 cfg_i,
  output logic                           done_o,
  output logic [patc_pkg::AIRTIME_W-1:0] airtime_ms_o
);

  logic [patc_pkg::M_W-1:0]    blk_num;
  logic                        blk_vld;
  logic [patc_pkg::BLK_W-1:0]  blk;

  logic                        a_vld_q, b_vld_q, c_vld_q, d_vld_q;
  logic [patc_pkg::BC_W-1:0]   bc_q, bc_d;
  logic [patc_pkg::QTR_W-1:0]  qtr_q, qtr_d;
  logic [patc_pkg::Q250_W-1:0] q250_q, q250_d;
  logic [patc_pkg::NUM_W-1:0]  num_q, num_d;

  // ceiling division: (m + d - 1) / d
  assign blk_num = item_i.m + patc_pkg::M_W'(item_i.d) - patc_pkg::M_W'(1);

  patc_div #(
    .NumW(patc_pkg::M_W),
    .DvsW(patc_pkg::D_W),
    .QuoW(patc_pkg::BLK_W)
  ) u_blk_div (
    .clk_i,
    .rst_ni,
    .valid_i   (valid_i),
    .dividend_i(blk_num),
    .divisor_i (item_i.d),
    .valid_o   (blk_vld),
    .quotient_o(blk)
  );

  always_comb begin
    bc_d   = patc_pkg::BC_W'(blk) * patc_pkg::BC_W'(cfg_i.cr);
    qtr_d  = patc_pkg::QTR_W'({cfg_i.pre, 2'b00}) + patc_pkg::QTR_BASE
           + patc_pkg::QTR_W'({bc_q, 2'b00});
    q250_d = patc_pkg::Q250_W'(qtr_q) * patc_pkg::MS_SCALE;
    num_d  = (patc_pkg::NUM_W'(q250_q) << cfg_i.sf) + patc_pkg::NUM_W'(cfg_i.bw)
           - patc_pkg::NUM_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      a_vld_q <= blk_vld;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bc_q   <= bc_d;
    qtr_q  <= qtr_d;
    q250_q <= q250_d;
    num_q  <= num_d;
  end

  patc_div #(
    .NumW(patc_pkg::NUM_W),
    .DvsW(patc_pkg::BW_W),
    .QuoW(patc_pkg::AIRTIME_W)
  ) u_bw_div (
    .clk_i,
    .rst_ni,
    .valid_i   (d_vld_q),
    .dividend_i(num_q),
    .divisor_i (cfg_i.bw),
    .valid_o   (done_o),
    .quotient_o(airtime_ms_o)
  );

endmodule

// ===== hw/rtl/packet_airtime_calculator_top.sv =====
// Top level of the packet airtime calculator: config registers, front, queue and back.
//
//   channel   direction  handshake                  payload
//   request   in         start high, busy low       payload_length_i
//   result    out        done_o, one-cycle strobe   airtime_ms_o
//   config    in         cfg_valid_i & cfg_ready_o  cfg_index_i, cfg_data_i
//
// One request per cycle sustained while busy stays low; the result passes through the
// front register, the queue, 8 stages of block division, four arithmetic stages and
// 26 stages of bandwidth division (one quotient bit each).
// Reset empties the pipeline and the queue and loads the register defaults.
// The result side cannot stall; busy rises only if the queue is full, which the back
// end, draining one request a cycle, never lets happen at the default queue depth of two.
module packet_airtime_calculator_top #(
  parameter int unsigned QueueDepth = patc_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [patc_pkg::LEN_W-1:0]      payload_length_i,
  output logic                            done_o,
  output logic [patc_pkg::AIRTIME_W-1:0]  airtime_ms_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [patc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [patc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  patc_pkg::cfg_t  cfg_q;
  patc_pkg::item_t front_item;
  patc_pkg::item_t back_item;
  logic            push;
  logic            full;
  logic            back_vld;

  assign cfg_ready_o = 1'b1;

  // out-of-range sf and bandwidth are clamped as they are written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= patc_pkg::CFG_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        patc_pkg::REG_SF:   cfg_q.sf   <= patc_pkg::clamp_sf(cfg_data_i[patc_pkg::SF_W-1:0]);
        patc_pkg::REG_BW:   cfg_q.bw   <= patc_pkg::clamp_bw(cfg_data_i[patc_pkg::BW_W-1:0]);
        patc_pkg::REG_CR:   cfg_q.cr   <= cfg_data_i[patc_pkg::CR_W-1:0];
        patc_pkg::REG_PRE:  cfg_q.pre  <= cfg_data_i[patc_pkg::PRE_W-1:0];
        patc_pkg::REG_LDRO: cfg_q.ldro <= cfg_data_i[0];
        patc_pkg::REG_CRC:  cfg_q.crc  <= cfg_data_i[0];
        default:            cfg_q      <= cfg_q;
      endcase
    end
  end

  patc_front u_front (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .payload_length_i,
    .cfg_i   (cfg_q),
    .full_i  (full),
    .push_o  (push),
    .item_o  (front_item)
  );

  patc_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .valid_o (back_vld),
    .item_o  (back_item)
  );

  patc_back u_back (
    .clk_i,
    .rst_ni,
    .valid_i     (back_vld),
    .item_i      (back_item),
    .cfg_i       (cfg_q),
    .done_o,
    .airtime_ms_o
  );

endmodule
